@@ rtl/core/lbvs_pkg.sv @@
// shared types, constants and helpers for the vertex skinning unit
`default_nettype none
package lbvs_pkg;

    localparam int NUM_BONES    = 256;
    localparam int FRAC_BITS    = 16;
    localparam int WORDS        = 12;
    localparam int BONE_IDX_W   = $clog2(NUM_BONES);
    localparam int WEIGHT_SHIFT = 15;
    localparam int WEIGHT_ONE   = 32768;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    localparam logic [1:0] WT_ONE  = 2'd0;
    localparam logic [1:0] WT_TWO  = 2'd1;
    localparam logic [1:0] WT_FOUR = 2'd2;
    localparam logic [1:0] WT_BAD  = 2'd3;

    typedef logic [WORDS-1:0][31:0] mat_t;
    typedef logic [2:0][31:0] vec_t;

    // control that travels with one bone read
    typedef struct packed {
        logic               first;
        logic               last;
        logic               err;
        logic               zero;
        logic signed [16:0] weight;
    } beat_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] a);
        logic [31:0] r;
        if (a > 66'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (a < -66'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = a[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/linear_blend_vertex_skinning_unit.sv @@
// Four-bone linear blend skinning unit.
// Input channel: in_valid/in_ready. operation 0 writes one Q16.16 matrix word
// (load_bone, load_slot, load_value) and gives no result; operation 1 skins
// one vertex (pos_x/y/z, weight_type, bone_ids, weights) and gives one result.
// Output channel: out_valid/out_ready carrying out_x/y/z and type_error.
// Throughput: one bone matrix of the memory is read per cycle while the output
// is not stalled; a load, a one-bone or an unknown-type vertex takes one step
// of the sequencer, a two-bone vertex two steps and a four-bone vertex four.
// Path: item, memory read, product, transform, weighted product, accumulator and
// output registers in turn; each further bone adds one read to the path.
// Reset clears all valid bits and the sequencer; the matrix memory is not
// cleared and every word must be loaded before a vertex reads it.
// When the receiver stalls the whole pipeline holds; nothing is lost and
// in_ready drops until the output register drains.
`default_nettype none
module linear_blend_vertex_skinning_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [7:0]           load_bone,
    input  wire logic [3:0]           load_slot,
    input  wire logic signed [31:0]   load_value,
    input  wire logic [1:0]           weight_type,
    input  wire logic [31:0]          bone_ids,
    input  wire logic [63:0]          weights,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [31:0]        out_z,
    output logic                      type_error
);

    logic               en;
    logic               rd_vld;
    lbvs_pkg::beat_t    rd_beat;
    lbvs_pkg::mat_t     rd_mat;
    lbvs_pkg::vec_t     rd_pos;
    logic               t_vld;
    lbvs_pkg::beat_t    t_beat;
    lbvs_pkg::vec_t     t_vec;

    // pipeline moves whenever the output register is free or its transfer completes
    assign en = !out_valid || out_ready;

    lbvs_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .load_bone   (load_bone),
        .load_slot   (load_slot),
        .load_value  (load_value),
        .weight_type (weight_type),
        .bone_ids    (bone_ids),
        .weights     (weights),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .rd_vld_reg  (rd_vld),
        .rd_beat_reg (rd_beat),
        .rd_mat_reg  (rd_mat),
        .rd_pos_reg  (rd_pos)
    );

    lbvs_xform u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .rd_vld     (rd_vld),
        .rd_beat    (rd_beat),
        .rd_mat     (rd_mat),
        .rd_pos     (rd_pos),
        .t_vld_reg  (t_vld),
        .t_beat_reg (t_beat),
        .t_reg      (t_vec)
    );

    lbvs_blend u_blend (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .t_vld          (t_vld),
        .t_beat         (t_beat),
        .t_in           (t_vec),
        .out_valid_reg  (out_valid),
        .out_x_reg      (out_x),
        .out_y_reg      (out_y),
        .out_z_reg      (out_z),
        .type_error_reg (type_error)
    );

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && type_error) |-> (out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0))
        else $error("unknown weight type with nonzero position");

    a_four_bone_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == lbvs_pkg::OP_SKIN
         && weight_type == lbvs_pkg::WT_FOUR) |=> !in_ready)
        else $error("four-bone vertex did not hold the sequencer");
`endif

endmodule
`default_nettype wire

@@ rtl/core/lbvs_seq.sv @@
// item sequencer and bone matrix memory, one bone matrix read per cycle while en is high
`default_nettype none
module lbvs_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [7:0]           load_bone,
    input  wire logic [3:0]           load_slot,
    input  wire logic signed [31:0]   load_value,
    input  wire logic [1:0]           weight_type,
    input  wire logic [31:0]          bone_ids,
    input  wire logic [63:0]          weights,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    output logic                      rd_vld_reg,
    output lbvs_pkg::beat_t           rd_beat_reg,
    output lbvs_pkg::mat_t            rd_mat_reg,
    output lbvs_pkg::vec_t            rd_pos_reg
);

    lbvs_pkg::mat_t mem [lbvs_pkg::NUM_BONES];

    logic               it_valid_reg;
    logic               it_op_reg;
    logic [7:0]         it_bone_reg;
    logic [3:0]         it_slot_reg;
    logic [31:0]        it_value_reg;
    logic [1:0]         it_type_reg;
    logic [31:0]        it_ids_reg;
    logic [63:0]        it_w_reg;
    lbvs_pkg::vec_t     it_pos_reg;
    logic [1:0]         cnt_reg;

    logic [1:0]         last_cnt;
    logic               last;
    logic               take;
    logic [7:0]         cur_id;
    logic [15:0]        cur_w;
    lbvs_pkg::beat_t    beat_next;
    logic               wr_ok;

    always_comb
    begin
        if (it_op_reg == lbvs_pkg::OP_LOAD)
            last_cnt = 2'd0;
        else if (it_type_reg == lbvs_pkg::WT_FOUR)
            last_cnt = 2'd3;
        else if (it_type_reg == lbvs_pkg::WT_TWO)
            last_cnt = 2'd1;
        else
            last_cnt = 2'd0;
    end

    assign last     = (cnt_reg == last_cnt);
    assign take     = it_valid_reg && en;
    assign in_ready = en && (!it_valid_reg || last);
    assign cur_id   = it_ids_reg[{cnt_reg, 3'b000} +: 8];
    assign cur_w    = it_w_reg[{cnt_reg, 4'b0000} +: 16];
    assign wr_ok    = ({1'b0, it_bone_reg} < 9'(lbvs_pkg::NUM_BONES))
                      && (it_slot_reg < 4'(lbvs_pkg::WORDS));

    always_comb
    begin
        beat_next.first = (cnt_reg == 2'd0);
        beat_next.last  = last;
        beat_next.err   = 1'b0;
        beat_next.zero  = !({1'b0, cur_id} < 9'(lbvs_pkg::NUM_BONES));
        case (it_type_reg)
            lbvs_pkg::WT_ONE:
                beat_next.weight = 17'sd32768;
            lbvs_pkg::WT_TWO:
                beat_next.weight = (cnt_reg == 2'd0) ? $signed({1'b0, it_w_reg[15:0]})
                                 : 17'(lbvs_pkg::WEIGHT_ONE) - $signed({1'b0, it_w_reg[15:0]});
            lbvs_pkg::WT_FOUR:
                beat_next.weight = $signed({1'b0, cur_w});
            default:
            begin
                beat_next.weight = 17'sd0;
                beat_next.err    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                it_valid_reg <= 1'b1;
                cnt_reg      <= 2'd0;
            end
            else if (take && last)
                it_valid_reg <= 1'b0;
            else if (take)
                cnt_reg <= cnt_reg + 2'd1;
            if (en)
                rd_vld_reg <= take && (it_op_reg == lbvs_pkg::OP_SKIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            it_op_reg    <= operation;
            it_bone_reg  <= load_bone;
            it_slot_reg  <= load_slot;
            it_value_reg <= load_value;
            it_type_reg  <= weight_type;
            it_ids_reg   <= bone_ids;
            it_w_reg     <= weights;
            it_pos_reg   <= {pos_z, pos_y, pos_x};
        end
        // loads are written in item order so earlier skins never see them
        if (take && (it_op_reg == lbvs_pkg::OP_LOAD) && wr_ok)
            mem[it_bone_reg[lbvs_pkg::BONE_IDX_W-1:0]][it_slot_reg] <= it_value_reg;
        if (en)
        begin
            rd_mat_reg  <= mem[cur_id[lbvs_pkg::BONE_IDX_W-1:0]];
            rd_beat_reg <= beat_next;
            rd_pos_reg  <= it_pos_reg;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lbvs_xform.sv @@
// per-bone affine transform: products stage, then row sum and saturation
`default_nettype none
module lbvs_xform (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             rd_vld,
    input  wire lbvs_pkg::beat_t  rd_beat,
    input  wire lbvs_pkg::mat_t   rd_mat,
    input  wire lbvs_pkg::vec_t   rd_pos,
    output logic                  t_vld_reg,
    output lbvs_pkg::beat_t       t_beat_reg,
    output lbvs_pkg::vec_t        t_reg
);

    logic signed [63:0] prod_reg [3][3];
    logic signed [31:0] trans_reg [3];
    logic               p_vld_reg;
    lbvs_pkg::beat_t    p_beat_reg;
    logic signed [65:0] row_sum [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = 66'(trans_reg[r])
                       + 66'(prod_reg[r][0] >>> lbvs_pkg::FRAC_BITS)
                       + 66'(prod_reg[r][1] >>> lbvs_pkg::FRAC_BITS)
                       + 66'(prod_reg[r][2] >>> lbvs_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= rd_vld;
            t_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_beat_reg <= rd_beat;
            for (int r = 0; r < 3; r++)
            begin
                // out-of-range bone acts as an all-zero matrix
                trans_reg[r] <= rd_beat.zero ? 32'sd0 : $signed(rd_mat[r*4+3]);
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= rd_beat.zero ? 64'sd0
                                    : $signed(rd_mat[r*4+c]) * $signed(rd_pos[c]);
            end
            t_beat_reg <= p_beat_reg;
            for (int r = 0; r < 3; r++)
                t_reg[r] <= lbvs_pkg::sat32(row_sum[r]);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lbvs_blend.sv @@
// weight multiply, accumulation over bones and saturated output register
`default_nettype none
module lbvs_blend (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             t_vld,
    input  wire lbvs_pkg::beat_t  t_beat,
    input  wire lbvs_pkg::vec_t   t_in,
    output logic                  out_valid_reg,
    output logic signed [31:0]    out_x_reg,
    output logic signed [31:0]    out_y_reg,
    output logic signed [31:0]    out_z_reg,
    output logic                  type_error_reg
);

    logic signed [48:0] q_reg [3];
    logic               q_vld_reg;
    lbvs_pkg::beat_t    q_beat_reg;
    logic signed [50:0] acc_reg [3];
    logic signed [50:0] acc_next [3];
    logic               done_reg;
    logic               err_reg;
    logic [31:0]        res [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = q_beat_reg.first ? 51'(q_reg[r]) : acc_reg[r] + 51'(q_reg[r]);
            res[r]      = lbvs_pkg::sat32(66'(acc_reg[r] >>> lbvs_pkg::WEIGHT_SHIFT));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg     <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg     <= t_vld;
            done_reg      <= q_vld_reg && q_beat_reg.last;
            out_valid_reg <= done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_beat_reg <= t_beat;
            for (int r = 0; r < 3; r++)
                q_reg[r] <= t_beat.weight * $signed(t_in[r]);
            if (q_vld_reg)
            begin
                for (int r = 0; r < 3; r++)
                    acc_reg[r] <= acc_next[r];
                err_reg <= q_beat_reg.err;
            end
            if (done_reg)
            begin
                type_error_reg <= err_reg;
                out_x_reg      <= err_reg ? 32'sd0 : $signed(res[0]);
                out_y_reg      <= err_reg ? 32'sd0 : $signed(res[1]);
                out_z_reg      <= err_reg ? 32'sd0 : $signed(res[2]);
            end
        end
    end

endmodule
`default_nettype wire

@@ bench/lbvs_checker.sv @@
// skinning result predictor and output checker
`timescale 1ns / 100ps
module lbvs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              operation,
    input  wire logic [7:0]        load_bone,
    input  wire logic [3:0]        load_slot,
    input  wire logic signed [31:0] load_value,
    input  wire logic [1:0]        weight_type,
    input  wire logic [31:0]       bone_ids,
    input  wire logic [63:0]       weights,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic signed [31:0] out_x,
    input  wire logic signed [31:0] out_y,
    input  wire logic signed [31:0] out_z,
    input  wire logic              type_error,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               err;
    } skinned_t;

    logic signed [31:0] matrix_words [lbvs_pkg::NUM_BONES*lbvs_pkg::WORDS];
    skinned_t           skinned_q[$];

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] a);
        if (a > 64'sd2147483647)
            return 64'sd2147483647;
        if (a < -64'sd2147483648)
            return -64'sd2147483648;
        return a;
    endfunction

    // arithmetic shift is a floor on signed values
    function automatic logic signed [63:0] transform_row(input int bone, input int row,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        logic signed [63:0] acc;
        int base;
        if (bone >= lbvs_pkg::NUM_BONES)
            return 0;
        base = bone * lbvs_pkg::WORDS + row * 4;
        acc = 64'(matrix_words[base+3]);
        acc += (64'(matrix_words[base]) * 64'(px)) >>> lbvs_pkg::FRAC_BITS;
        acc += (64'(matrix_words[base+1]) * 64'(py)) >>> lbvs_pkg::FRAC_BITS;
        acc += (64'(matrix_words[base+2]) * 64'(pz)) >>> lbvs_pkg::FRAC_BITS;
        return clamp32(acc);
    endfunction

    function automatic skinned_t skin_vertex();
        skinned_t s;
        logic signed [31:0] row_out [3];
        logic signed [63:0] acc;
        logic signed [63:0] w0;
        s = '0;
        w0 = 64'(weights[15:0]);
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            case (weight_type)
                lbvs_pkg::WT_ONE: acc = transform_row(bone_ids[7:0], r, pos_x, pos_y, pos_z);
                lbvs_pkg::WT_TWO:
                begin
                    acc = w0 * transform_row(bone_ids[7:0], r, pos_x, pos_y, pos_z)
                        + (64'sd32768 - w0)
                        * transform_row(bone_ids[15:8], r, pos_x, pos_y, pos_z);
                    acc = clamp32(acc >>> lbvs_pkg::WEIGHT_SHIFT);
                end
                lbvs_pkg::WT_FOUR:
                begin
                    for (int k = 0; k < 4; k++)
                        acc += 64'(weights[16*k +: 16])
                            * transform_row(bone_ids[8*k +: 8], r, pos_x, pos_y, pos_z);
                    acc = clamp32(acc >>> lbvs_pkg::WEIGHT_SHIFT);
                end
                default: s.err = 1'b1;
            endcase
            row_out[r] = acc[31:0];
        end
        s.x = row_out[0];
        s.y = row_out[1];
        s.z = row_out[2];
        return s;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        skinned_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (skinned_q.size() == 0)
                    report("unexpected result", out_x, 32'd0);
                else
                begin
                    want = skinned_q.pop_front();
                    if (out_x !== want.x) report("out_x", out_x, want.x);
                    if (out_y !== want.y) report("out_y", out_y, want.y);
                    if (out_z !== want.z) report("out_z", out_z, want.z);
                    if (type_error !== want.err)
                        report("type_error", 32'(type_error), 32'(want.err));
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == lbvs_pkg::OP_LOAD)
                begin
                    if (load_slot < lbvs_pkg::WORDS && load_bone < lbvs_pkg::NUM_BONES)
                        matrix_words[load_bone*lbvs_pkg::WORDS + load_slot] = load_value;
                end
                else
                    skinned_q.push_back(skin_vertex());
            end
        end
        pending = skinned_q.size();
    end

endmodule

@@ bench/tb.sv @@
// stimulus and verdict for the vertex skinning unit
`timescale 1ns / 100ps
module tb;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [7:0]        load_bone;
    logic [3:0]        load_slot;
    logic signed [31:0] load_value;
    logic [1:0]        weight_type;
    logic [31:0]       bone_ids;
    logic [63:0]       weights;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic              out_valid;
    logic              out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    logic              type_error;
    int                errors;
    int                pending;
    int                cycles;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                bone_loaded [lbvs_pkg::NUM_BONES];

    linear_blend_vertex_skinning_unit dut (.*);

    lbvs_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("linear_blend_vertex_skinning_unit regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // one transfer; valid stays high into the next item unless the sender idles
    task automatic send_item();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_word(input int bone, input int slot, input logic [31:0] value);
        operation  <= lbvs_pkg::OP_LOAD;
        load_bone  <= 8'(bone);
        load_slot  <= 4'(slot);
        load_value <= value;
        send_item();
    endtask

    function automatic logic [31:0] matrix_value(input int slot);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:
                // mostly near identity so the sums stay in range
                return (slot % 5 == 0) ? 32'h0001_0000 + $urandom_range(8191) - 4096
                                       : $urandom_range(131071) - 65536;
        endcase
    endfunction

    task automatic load_bone_matrix(input int bone);
        for (int s = 0; s < lbvs_pkg::WORDS; s++)
            load_word(bone, s, matrix_value(s));
        bone_loaded[bone] = 1'b1;
    endtask

    // bone index: loaded, or beyond the table is impossible at 8 bits, so loaded only
    function automatic logic [7:0] pick_bone();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (!bone_loaded[b]);
        return b;
    endfunction

    function automatic logic [31:0] position();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task automatic skin(input logic [1:0] wt, input logic [63:0] w,
            input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
        logic [31:0] ids;
        for (int k = 0; k < 4; k++)
            ids[8*k +: 8] = pick_bone();
        operation   <= lbvs_pkg::OP_SKIN;
        weight_type <= wt;
        bone_ids    <= ids;
        weights     <= w;
        pos_x       <= px;
        pos_y       <= py;
        pos_z       <= pz;
        send_item();
    endtask

    task automatic skin_random();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(1))
            for (int k = 0; k < 4; k++)
                w[16*k +: 16] = 16'($urandom_range(lbvs_pkg::WEIGHT_ONE));
        skin(2'($urandom), w, position(), position(), position());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = lbvs_pkg::OP_LOAD;
        load_bone      = '0;
        load_slot      = '0;
        load_value     = '0;
        weight_type    = lbvs_pkg::WT_ONE;
        bone_ids       = '0;
        weights        = '0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme bones, out-of-range slots, every weight type
        load_bone_matrix(0);
        load_bone_matrix(255);
        load_word(0, 15, 32'hDEAD_BEEF);
        load_word(255, 12, 32'h1234_5678);
        skin(lbvs_pkg::WT_ONE, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        skin(lbvs_pkg::WT_TWO, 64'h0000_0000_0000_8000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
        skin(lbvs_pkg::WT_TWO, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000);
        skin(lbvs_pkg::WT_FOUR, 64'h8000_8000_8000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF);
        skin(lbvs_pkg::WT_FOUR, 64'h0, 32'h1, 32'h2, 32'h3);
        skin(lbvs_pkg::WT_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h2);
        drain();

        for (int b = 1; b < 255; b += 1 + $urandom_range(19))
            load_bone_matrix(b);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 75 : 8) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 75 : 8) : 0;
            for (int i = 0; i < 200; i++)
            begin
                if ($urandom_range(19) == 0)
                    load_word($urandom_range(1) ? pick_bone() : $urandom,
                              $urandom_range(15), $urandom);
                else
                    skin_random();
                if (i == 100)
                    drain();
            end
            // untouched bones become usable once fully written
            load_bone_matrix($urandom_range(255));
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();

        if (errors == 0)
            $display("linear_blend_vertex_skinning_unit regression: pass");
        else
            $display("linear_blend_vertex_skinning_unit regression: fail");
        $finish;
    end

endmodule
